[hdl/bffa_pkg.sv]
// Shared constants and controller/datapath interface types for the block allocator.
package bffa_pkg;

	// Storage geometry
	localparam int MAP_BLOCKS  = 512;
	localparam int BLOCK_BYTES = 2048;

	// Field widths of the request and result
	localparam int SIZE_W  = 21;
	localparam int START_W = 9;
	localparam int COUNT_W = 10;

	// Internal widths
	localparam int ADDR_W = $clog2(MAP_BLOCKS);
	localparam int CNT_W  = $clog2(MAP_BLOCKS + 1);
	localparam int NEED_W = SIZE_W + 1;

	// Request operation codes
	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;     // take the request fields
		logic scan;     // run the first-fit scan
		logic wr;       // write one map bit at the write pointer
		logic wr_val;   // value written
		logic set_fail; // pending result: failure
		logic set_pass; // pending result: success, start 0
		logic emit;     // move pending result to the output register
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic is_free;   // incoming request is a free
		logic free_zero; // incoming free has zero count
		logic free_bad;  // incoming free runs past the last block
		logic need_bad;  // incoming allocate needs zero or too many blocks
		logic found;     // scan found a fitting run this cycle
		logic scan_miss; // scan checked the last block without a fit
		logic wr_last;   // current write is the last of the run
	} dp_sts_t;

endpackage

[hdl/bffa_ram.sv]
// Generic simple dual-port RAM with registered read.
module bffa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 512,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/bffa_dp.sv]
// Datapath: occupancy map, scan counters, run tracking and result registers.
module bffa_dp
	import bffa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               op,
	input  logic [SIZE_W-1:0]  size_bytes,
	input  logic [START_W-1:0] free_start,
	input  logic [COUNT_W-1:0] free_count,
	input  dp_cmd_t            cmd,
	output dp_sts_t            sts,
	output logic               ok,
	output logic [START_W-1:0] first_block
);

	logic [NEED_W-1:0] need;
	logic [COUNT_W:0]  free_end;
	logic [CNT_W-1:0]  need_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ADDR_W-1:0] ptr_q;
	logic [CNT_W-1:0]  left_q;
	logic              chk_vld_s1;
	logic [ADDR_W-1:0] chk_addr_s1;
	logic [ADDR_W-1:0] run_start_q;
	logic [CNT_W-1:0]  run_len_q;
	logic              rslt_ok_q;
	logic [ADDR_W-1:0] rslt_start_q;
	logic              out_ok_q;
	logic [ADDR_W-1:0] out_start_q;
	logic              issue;
	logic              found;
	logic [ADDR_W-1:0] found_start;
	logic              rd_data;

	// Request decode: blocks needed, free range end
	assign need     = (NEED_W'(size_bytes) + NEED_W'(BLOCK_BYTES - 1)) / NEED_W'(BLOCK_BYTES);
	assign free_end = (COUNT_W + 1)'(free_start) + (COUNT_W + 1)'(free_count);

	// Scan: one map read per cycle, result checked in the cycle after its read
	assign issue       = cmd.scan && (cnt_q < CNT_W'(MAP_BLOCKS)) && !found;
	assign found       = cmd.scan && chk_vld_s1 && !rd_data
		&& ((run_len_q + CNT_W'(1)) == need_q);
	assign found_start = (run_len_q == '0) ? chk_addr_s1 : run_start_q;

	always_comb begin
		sts           = '0;
		sts.is_free   = (op == OP_FREE);
		sts.free_zero = (free_count == '0);
		sts.free_bad  = (free_end > (COUNT_W + 1)'(MAP_BLOCKS));
		sts.need_bad  = (need == '0) || (need > NEED_W'(MAP_BLOCKS));
		sts.found     = found;
		sts.scan_miss = cmd.scan && chk_vld_s1 && !found
			&& (chk_addr_s1 == ADDR_W'(MAP_BLOCKS - 1));
		sts.wr_last   = (left_q == CNT_W'(1));
	end

	// Occupancy map, one bit per block
	bffa_ram #(
		.WIDTH(1),
		.DEPTH(MAP_BLOCKS)
	) u_map (
		.clk  (clk),
		.we   (cmd.wr),
		.waddr(ptr_q),
		.wdata(cmd.wr_val),
		.re   (issue),
		.raddr(cnt_q[ADDR_W-1:0]),
		.rdata(rd_data)
	);

	// Scan counter, check stage and run tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			chk_vld_s1 <= 1'b0;
			run_len_q  <= '0;
		end else if (cmd.load) begin
			cnt_q      <= '0;
			chk_vld_s1 <= 1'b0;
			run_len_q  <= '0;
		end else begin
			chk_vld_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.scan && chk_vld_s1) begin
				if (!rd_data) begin
					run_len_q <= run_len_q + CNT_W'(1);
				end else begin
					run_len_q <= '0;
				end
			end
		end
	end

	// Check-stage payload
	always_ff @(posedge clk) begin
		if (issue) begin
			chk_addr_s1 <= cnt_q[ADDR_W-1:0];
		end
		if (cmd.scan && chk_vld_s1 && !rd_data && run_len_q == '0) begin
			run_start_q <= chk_addr_s1;
		end
		if (cmd.load) begin
			need_q <= CNT_W'(need);
		end
	end

	// Write pointer and remaining count; reset values sweep the whole map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			left_q <= CNT_W'(MAP_BLOCKS);
		end else if (cmd.wr) begin
			ptr_q  <= ptr_q + ADDR_W'(1);
			left_q <= left_q - CNT_W'(1);
		end else if (cmd.load && op == OP_FREE) begin
			ptr_q  <= ADDR_W'(free_start);
			left_q <= CNT_W'(free_count);
		end else if (found) begin
			ptr_q  <= found_start;
			left_q <= need_q;
		end
	end

	// Pending result and output register
	always_ff @(posedge clk) begin
		if (cmd.set_fail || cmd.set_pass) begin
			rslt_ok_q    <= cmd.set_pass;
			rslt_start_q <= '0;
		end else if (found) begin
			rslt_ok_q    <= 1'b1;
			rslt_start_q <= found_start;
		end
		if (cmd.emit) begin
			out_ok_q    <= rslt_ok_q;
			out_start_q <= rslt_start_q;
		end
	end

	assign ok          = out_ok_q;
	assign first_block = START_W'(out_start_q);

endmodule

[hdl/bffa_ctrl.sv]
// Controller: sequences map clearing, scan, marking, freeing and result handoff.
module bffa_ctrl
	import bffa_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_MARK,
		ST_FREE,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state and datapath commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.wr = 1'b1;
				if (sts.wr_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (sts.is_free) begin
						if (sts.free_bad) begin
							cmd.set_fail = 1'b1;
							state_nxt    = ST_DONE;
						end else if (sts.free_zero) begin
							cmd.set_pass = 1'b1;
							state_nxt    = ST_DONE;
						end else begin
							state_nxt = ST_FREE;
						end
					end else if (sts.need_bad) begin
						cmd.set_fail = 1'b1;
						state_nxt    = ST_DONE;
					end else begin
						state_nxt = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.found) begin
					state_nxt = ST_MARK;
				end else if (sts.scan_miss) begin
					cmd.set_fail = 1'b1;
					state_nxt    = ST_DONE;
				end
			end
			ST_MARK: begin
				cmd.wr     = 1'b1;
				cmd.wr_val = 1'b1;
				if (sts.wr_last) begin
					state_nxt = ST_DONE;
				end
			end
			ST_FREE: begin
				cmd.wr = 1'b1;
				if (sts.wr_last) begin
					cmd.set_pass = 1'b1;
					state_nxt    = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	// A result never overwrites one that is still waiting
	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || !out_stall))
		else $error("result emitted over a waiting result");

	// An accepted request keeps the input stalled while it is worked on
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after request accepted");

	// Scanning and map writes never overlap
	a_scan_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.scan && cmd.wr))
		else $error("scan and map write in the same cycle");

	// Only one pending-result update per cycle
	a_rslt_single: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.set_fail && cmd.set_pass) && !(sts.found && cmd.set_fail))
		else $error("conflicting result updates");
`endif

endmodule

[hdl/bitmap_first_fit_block_allocator.sv]
// Bitmap first-fit contiguous block allocator, top level.
// The block keeps one occupancy bit per block in a single-bit-wide RAM with one
// write and one registered read port. After reset it sweeps all MAP_BLOCKS (512)
// entries of that RAM to mark every block free, and keeps in_stall high
// meanwhile. Requests are taken one at a time. An allocate rounds size_bytes up
// to whole blocks, then reads the map one block per cycle from block 0 until it
// has a free run of that length, then writes one bit per cycle to mark the run.
// A free makes one map write per block. Rejected requests (zero size, too
// large, range past the last block) skip the map and go straight to the result.
// Each request gives one result, held in an output register, so the next
// request can be accepted while that result waits to be taken.
module bitmap_first_fit_block_allocator
	import bffa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [SIZE_W-1:0]  size_bytes,
	input  logic [START_W-1:0] free_start,
	input  logic [COUNT_W-1:0] free_count,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               ok,
	output logic [START_W-1:0] first_block
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencer
	bffa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Map, counters and result registers
	bffa_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.size_bytes (size_bytes),
		.free_start (free_start),
		.free_count (free_count),
		.cmd        (cmd),
		.sts        (sts),
		.ok         (ok),
		.first_block(first_block)
	);

endmodule

[bench/block_alloc_checker.sv]
// Checker for the block allocator: mirrors the occupancy map and checks each result in order.
`timescale 1ns / 1ps

module block_alloc_checker
	import bffa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               op,
	input  logic [SIZE_W-1:0]  size_bytes,
	input  logic [START_W-1:0] free_start,
	input  logic [COUNT_W-1:0] free_count,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               ok,
	input  logic [START_W-1:0] first_block,
	output int                 mismatch_count,
	output int                 outstanding
);

	typedef struct packed {
		logic               ok;
		logic [START_W-1:0] start;
	} grant_t;

	// Mirror of the occupancy map, 1 = block in use
	logic [MAP_BLOCKS-1:0] used_map;
	// Results still owed by the block, oldest first
	grant_t                grant_queue[$];

	// First fit: round up to whole blocks, scan from block 0, claim the first free run
	function automatic grant_t allocate_run(logic [SIZE_W-1:0] bytes);
		grant_t res;
		int     need;
		int     run_len;
		int     run_first;
		res = '0;
		need = (int'(bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
		run_len = 0;
		run_first = 0;
		// zero size and oversize requests fail without a scan
		if (need == 0 || need > MAP_BLOCKS)
			return res;
		for (int i = 0; i < MAP_BLOCKS; i++) begin
			if (used_map[i]) begin
				run_len = 0;
			end else begin
				if (run_len == 0)
					run_first = i;
				run_len++;
				if (run_len == need) begin
					for (int j = run_first; j < run_first + need; j++)
						used_map[j] = 1'b1;
					res.ok = 1'b1;
					res.start = START_W'(run_first);
					return res;
				end
			end
		end
		return res;
	endfunction

	// Release: range past the last block fails untouched; otherwise clear (already-free is fine)
	function automatic grant_t release_run(logic [START_W-1:0] first, logic [COUNT_W-1:0] count);
		grant_t res;
		res = '0;
		if (int'(first) + int'(count) > MAP_BLOCKS)
			return res;
		for (int j = int'(first); j < int'(first) + int'(count); j++)
			used_map[j] = 1'b0;
		res.ok = 1'b1;
		return res;
	endfunction

	// Watch both channels; results are checked before the new request is predicted,
	// since a result never belongs to a request taken on the same edge
	always @(posedge clk or negedge arst_n) begin : watch
		grant_t exp_grant;
		logic   bad;
		if (!arst_n) begin
			used_map = '0;
			grant_queue.delete();
			mismatch_count = 0;
			outstanding = 0;
		end else begin
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (grant_queue.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected result ok=%0b first_block=%0d",
							$time, ok, first_block);
				end else begin
					exp_grant = grant_queue.pop_front();
					bad = 1'b0;
					if (ok !== exp_grant.ok)
						bad = 1'b1;
					if (first_block !== exp_grant.start)
						bad = 1'b1;
					if (bad) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: mismatch ok exp %0b got %0b, first_block exp %0d got %0d",
								$time, exp_grant.ok, ok, exp_grant.start, first_block);
					end
				end
			end
			if (in_valid === 1'b1 && in_stall === 1'b0) begin
				if (op_t'(op) == OP_ALLOC)
					grant_queue.push_back(allocate_run(size_bytes));
				else
					grant_queue.push_back(release_run(free_start, free_count));
			end
			outstanding = grant_queue.size();
		end
	end

endmodule

[bench/bitmap_first_fit_block_allocator_tb.sv]
// Testbench top for the block allocator: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module bitmap_first_fit_block_allocator_tb
	import bffa_pkg::*;
();

	localparam int RANDOM_ITEMS = 1150;
	localparam int QUIET_FROM   = RANDOM_ITEMS - 120;

	typedef struct {
		int first;
		int len;
	} run_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	op_t                op;
	logic [SIZE_W-1:0]  size_bytes;
	logic [START_W-1:0] free_start;
	logic [COUNT_W-1:0] free_count;
	logic               out_valid;
	logic               out_stall;
	logic               ok;
	logic [START_W-1:0] first_block;
	int                 mismatch_count;
	int                 outstanding;
	bit                 quiet = 1'b0;

	// Blocks asked for by each request in flight (0 for a free), and runs known to be held
	int                 blocks_in_flight[$];
	run_t               live_runs[$];

	bitmap_first_fit_block_allocator u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.size_bytes (size_bytes),
		.free_start (free_start),
		.free_count (free_count),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.ok         (ok),
		.first_block(first_block)
	);

	block_alloc_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.size_bytes    (size_bytes),
		.free_start    (free_start),
		.free_count    (free_count),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.ok            (ok),
		.first_block   (first_block),
		.mismatch_count(mismatch_count),
		.outstanding   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#50_000_000;
		$display("Verification failed");
		$finish;
	end

	// Learn which runs were granted so later frees can return them whole
	always @(posedge clk) begin : track_grants
		int need;
		if (out_valid === 1'b1 && out_stall === 1'b0 && blocks_in_flight.size() > 0) begin
			need = blocks_in_flight.pop_front();
			if (need > 0 && ok === 1'b1)
				live_runs.push_back('{int'(first_block), need});
		end
	end

	// Result side: stall in random bursts, none in the last stretch
	initial begin : receiver
		int span;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (quiet) begin
				out_stall <= 1'b0;
			end else begin
				span = $urandom_range(1, 10);
				out_stall <= ($urandom_range(0, 2) == 0);
				repeat (span - 1) @(negedge clk);
			end
		end
	end

	// Present one request at a falling edge and hold it until taken
	task automatic send_request(op_t kind, logic [SIZE_W-1:0] sz,
		logic [START_W-1:0] first, logic [COUNT_W-1:0] count);
		in_valid <= 1'b1;
		op <= kind;
		size_bytes <= sz;
		free_start <= first;
		free_count <= count;
		do @(posedge clk); while (in_stall !== 1'b0);
		blocks_in_flight.push_back(kind == OP_ALLOC ?
			(int'(sz) + BLOCK_BYTES - 1) / BLOCK_BYTES : 0);
		@(negedge clk);
	endtask

	// Unused fields carry random values
	task automatic do_alloc(logic [SIZE_W-1:0] sz);
		send_request(OP_ALLOC, sz, START_W'($urandom), COUNT_W'($urandom));
	endtask

	task automatic do_free(logic [START_W-1:0] first, logic [COUNT_W-1:0] count);
		send_request(OP_FREE, SIZE_W'($urandom), first, count);
	endtask

	task automatic pause_sender(int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	// Byte size that rounds up to exactly n blocks, with a random tail
	function automatic logic [SIZE_W-1:0] bytes_for_blocks(int n);
		return SIZE_W'((n - 1) * BLOCK_BYTES + $urandom_range(1, BLOCK_BYTES));
	endfunction

	initial begin : stimulus
		int   r;
		int   k;
		run_t victim;
		in_valid = 1'b0;
		op = OP_ALLOC;
		size_bytes = '0;
		free_start = '0;
		free_count = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed corners
		do_alloc('0);                                   // zero size
		do_alloc(SIZE_W'(1));                           // one byte, one block
		do_alloc(SIZE_W'(BLOCK_BYTES));                 // exactly one block
		do_alloc(SIZE_W'(BLOCK_BYTES + 1));             // rounds up to two
		do_alloc(SIZE_W'(MAP_BLOCKS * BLOCK_BYTES));    // whole device, no room left
		do_alloc('1);                                   // larger than the device
		do_free(START_W'(MAP_BLOCKS - 1), COUNT_W'(2)); // runs past the end
		do_free('0, '1);                                // huge count
		do_free('0, '0);                                // zero length
		do_free(START_W'(MAP_BLOCKS - 1), COUNT_W'(1)); // block already free
		do_free(START_W'(1), COUNT_W'(1));              // hole at block 1
		do_alloc(SIZE_W'(BLOCK_BYTES));                 // should land in the hole
		do_free('0, COUNT_W'(MAP_BLOCKS));              // free everything
		do_alloc(SIZE_W'(MAP_BLOCKS * BLOCK_BYTES));    // whole device fits
		do_alloc(SIZE_W'(1));                           // map full
		do_free('1, COUNT_W'(1));                       // open the last block
		do_alloc(SIZE_W'(1));                           // takes the last block
		do_free('0, COUNT_W'(MAP_BLOCKS));
		do_alloc(SIZE_W'(MAP_BLOCKS * BLOCK_BYTES - 1));
		do_free('1, '0);                                // zero length at the top
		do_free(START_W'(MAP_BLOCKS / 2), COUNT_W'(MAP_BLOCKS / 2));
		do_free('0, COUNT_W'(MAP_BLOCKS / 2));
		wait_for_results();

		// Random traffic: mostly small allocations and frees of granted runs
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == QUIET_FROM)
				quiet <= 1'b1;
			if (n == RANDOM_ITEMS / 3)
				wait_for_results();
			if (n < QUIET_FROM && $urandom_range(0, 3) == 0)
				pause_sender($urandom_range(1, 10));
			r = $urandom_range(0, 99);
			if (r < 50) begin
				do_alloc(bytes_for_blocks($urandom_range(1, 16)));
			end else if (r < 54) begin
				do_alloc(bytes_for_blocks($urandom_range(17, 64)));
			end else if (r < 55) begin
				do_alloc(bytes_for_blocks(MAP_BLOCKS));
			end else if (r < 58) begin
				do_alloc(SIZE_W'($urandom));
			end else if (r < 59) begin
				do_alloc('0);
			end else if (r < 85 && live_runs.size() > 0) begin
				k = $urandom_range(0, live_runs.size() - 1);
				victim = live_runs[k];
				live_runs.delete(k);
				do_free(START_W'(victim.first), COUNT_W'(victim.len));
			end else if (r < 94) begin
				do_free(START_W'($urandom), COUNT_W'($urandom_range(0, 24)));
			end else if (r < 99) begin
				do_free(START_W'($urandom), COUNT_W'($urandom));
			end else begin
				do_free(START_W'($urandom), '0);
			end
		end

		// Drain, then give a stray late result time to show up
		wait_for_results();
		repeat (2 * MAP_BLOCKS + 64) @(negedge clk);
		if (mismatch_count == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
